// ===== sv/crl_pkg.sv =====
// ----------------------------------------------------------------------------
// crl_pkg
// Shared types and constants of the color ramp lookup.
// ----------------------------------------------------------------------------
package crl_pkg;

  localparam int MaxLevelsDefault = 16;
  localparam int DivBits = 33;

  localparam logic [1:0] CmdPixel = 2'd0;
  localparam logic [1:0] CmdLevel = 2'd1;
  localparam logic [1:0] CmdColor = 2'd2;

  localparam logic [1:0] ClassInside  = 2'd0;
  localparam logic [1:0] ClassBelow   = 2'd1;
  localparam logic [1:0] ClassAbove   = 2'd2;
  localparam logic [1:0] ClassMissing = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [4:0]  index;
    logic signed [31:0] elevation;
    logic        is_nan;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
  } crl_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] band_class;
  } crl_out_t;

endpackage

// ===== sv/crl_if.sv =====
// ----------------------------------------------------------------------------
// crl_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface crl_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/crl_front.sv =====
// ----------------------------------------------------------------------------
// crl_front
// Holds the level table, classifies a pixel against the levels in use and
// passes a job with its bracketing entries to the back part.
// ----------------------------------------------------------------------------
module crl_front
  import crl_pkg::*;
#(
  parameter int MAX_LEVELS = MaxLevelsDefault,
  parameter int LW = $clog2(MAX_LEVELS + 1) > 5 ? $clog2(MAX_LEVELS + 1) : 5,
  parameter int CW = $clog2(MAX_LEVELS + 3)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  crl_in_t                in_data,
  input  logic [LW-1:0]          count,
  output logic                   job_valid,
  input  logic                   job_ready,
  output logic                   job_interp,
  output logic [1:0]             job_class,
  output logic [CW-1:0]          job_sel,
  output logic [32:0]            job_d,
  output logic [32:0]            job_n,
  output logic                   cw_en,
  output logic [CW-1:0]          cw_addr,
  output logic [23:0]            cw_data
);

  localparam int IW = MAX_LEVELS > 1 ? $clog2(MAX_LEVELS) : 1;

  logic signed [31:0] levels [MAX_LEVELS];
  logic [LW-1:0] n_eff;
  logic [IW-1:0] top, pick;
  logic found;
  logic acc;
  logic signed [32:0] lo, hi, v;

  assign in_ready = !job_valid || job_ready;
  assign acc = in_valid && in_ready;

  always_comb begin
    n_eff = count;
    if (count == '0) n_eff = LW'(1);
    if (count > LW'(MAX_LEVELS)) n_eff = LW'(MAX_LEVELS);
    top = IW'(n_eff - LW'(1));
    pick = top;
    found = 1'b0;
    for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
      if (i < int'(n_eff) && levels[i] >= in_data.elevation) begin
        pick = IW'(i);
        found = 1'b1;
      end
    end
    hi = 33'(levels[pick]);
    lo = (pick == '0) ? hi : 33'(levels[pick - IW'(1)]);
    v = 33'(in_data.elevation);
  end

  always_ff @(posedge clk) begin
    if (acc && in_data.cmd == CmdLevel && in_data.index < 5'(MAX_LEVELS))
      levels[IW'(in_data.index)] <= in_data.elevation;
  end

  assign cw_en = acc && in_data.cmd == CmdColor && in_data.index < 5'(MAX_LEVELS + 3);
  assign cw_addr = CW'(in_data.index);
  assign cw_data = {in_data.red_in, in_data.green_in, in_data.blue_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (in_ready) begin
      job_valid <= in_valid && in_data.cmd == CmdPixel;
    end
    if (acc) begin
      job_interp <= 1'b0;
      job_d <= 33'(hi - lo);
      job_n <= 33'(v - lo);
      if (in_data.is_nan) begin
        job_class <= ClassMissing;
        job_sel <= CW'(n_eff + LW'(2));
      end else if (in_data.elevation > levels[top]) begin
        job_class <= ClassAbove;
        job_sel <= CW'(n_eff + LW'(1));
      end else if (in_data.elevation < levels[0]) begin
        job_class <= ClassBelow;
        job_sel <= CW'(n_eff);
      end else begin
        job_class <= ClassInside;
        job_sel <= CW'(pick);
        job_interp <= found && pick != '0 && levels[pick] != in_data.elevation;
      end
    end
  end

endmodule

// ===== sv/crl_back.sv =====
// ----------------------------------------------------------------------------
// crl_back
// Holds the color table and produces each pixel, blending by a serial
// restoring division when the sample lies between two levels.
// ----------------------------------------------------------------------------
module crl_back
  import crl_pkg::*;
#(
  parameter int MAX_LEVELS = MaxLevelsDefault,
  parameter int CW = $clog2(MAX_LEVELS + 3)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  output logic            job_ready,
  input  logic            job_interp,
  input  logic [1:0]      job_class,
  input  logic [CW-1:0]   job_sel,
  input  logic [32:0]     job_d,
  input  logic [32:0]     job_n,
  input  logic            cw_en,
  input  logic [CW-1:0]   cw_addr,
  input  logic [23:0]     cw_data,
  output logic            out_valid,
  input  logic            out_ready,
  output crl_out_t        out_data
);

  typedef enum logic [2:0] {Idle, Read, Div, Done} state_t;
  localparam int NW = 43;
  localparam int QW = 11;

  state_t state;
  logic [23:0] colors [MAX_LEVELS + 3];
  logic [23:0] c0, c1;
  logic interp;
  logic [1:0] cls;
  logic [32:0] d, n;
  logic [1:0] ch;
  logic [5:0] bitc;
  logic [NW-1:0] num;
  logic [NW-1:0] num_init;
  logic [34:0] rem;
  logic [QW-1:0] quo;
  logic [QW-1:0] quo_step;
  logic [7:0] rch, gch;
  logic [7:0] a0, a1;
  logic [34:0] rem_sh, rem_try;
  logic [7:0] qsat;

  assign job_ready = state == Idle;

  always_ff @(posedge clk) begin
    if (cw_en) colors[cw_addr] <= cw_data;
  end

  always_comb begin
    case (ch)
      2'd0: begin a0 = c0[23:16]; a1 = c1[23:16]; end
      2'd1: begin a0 = c0[15:8]; a1 = c1[15:8]; end
      default: begin a0 = c0[7:0]; a1 = c1[7:0]; end
    endcase
    num_init = ((NW'(a0) * NW'(d - n) + NW'(a1) * NW'(n)) << 1) + NW'(d);
    rem_sh = {rem[33:0], num[NW-1]};
    rem_try = rem_sh - {1'b0, d, 1'b0};
    quo_step = {quo[QW-2:0], !rem_try[34]};
    qsat = (quo_step > QW'(255)) ? 8'd255 : quo_step[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Idle;
      out_valid <= 1'b0;
    end else begin
      case (state)
        Idle: begin
          if (job_valid) begin
            interp <= job_interp; cls <= job_class;
            d <= job_d; n <= job_n;
            c0 <= colors[job_sel - CW'(1)];
            c1 <= colors[job_sel];
            state <= Read;
          end
        end
        Read: begin
          if (interp) begin
            ch <= 2'd0;
            bitc <= '0;
            num <= '0;
            state <= Div;
          end else begin
            out_data <= {c1, cls};
            out_valid <= 1'b1;
            state <= Done;
          end
        end
        Div: begin
          if (bitc == '0) begin
            num <= num_init;
            rem <= '0;
            quo <= '0;
            bitc <= 6'd1;
          end else begin
            num <= {num[NW-2:0], 1'b0};
            rem <= rem_try[34] ? rem_sh : rem_try;
            quo <= quo_step;
            if (bitc == 6'(NW)) begin
              bitc <= '0;
              ch <= ch + 2'd1;
              case (ch)
                2'd0: rch <= qsat;
                2'd1: gch <= qsat;
                default: begin
                  out_data <= {rch, gch, qsat, ClassInside};
                  out_valid <= 1'b1;
                  state <= Done;
                end
              endcase
            end else begin
              bitc <= bitc + 6'd1;
            end
          end
        end
        Done: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= Idle;
          end
        end
        default: state <= Idle;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == Done)
    else $error("result shown outside done state");
  assert property (@(posedge clk) disable iff (rst) job_ready |-> !out_valid)
    else $error("job taken while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (state == Div) |-> interp) else $error("division without blend");

endmodule

// ===== sv/color_ramp_lookup.sv =====
// ----------------------------------------------------------------------------
// color_ramp_lookup
// Elevation to RGB lookup through a level table and a color table.
// ----------------------------------------------------------------------------
// Level and color writes are taken whenever the front part is ready. A pixel
// with a table color is read from the color table and returned; a blended
// pixel goes through the serial divider, one channel after another.
module color_ramp_lookup
  import crl_pkg::*;
#(
  parameter int MAX_LEVELS = MaxLevelsDefault
) (
  input  logic clk,
  input  logic rst,
  crl_if.sink   in_ch,
  crl_if.source out_ch,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);

  localparam int LW = $clog2(MAX_LEVELS + 1) > 5 ? $clog2(MAX_LEVELS + 1) : 5;
  localparam int CW = $clog2(MAX_LEVELS + 3);

  logic [LW-1:0] level_count;
  logic job_valid, job_ready, job_interp, cw_en;
  logic [1:0] job_class;
  logic [CW-1:0] job_sel, cw_addr;
  logic [32:0] job_d, job_n;
  logic [23:0] cw_data;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) level_count <= LW'(1);
    else if (cfg_valid) level_count <= LW'(cfg_data);
  end

  crl_front #(.MAX_LEVELS(MAX_LEVELS), .LW(LW), .CW(CW)) u_front (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .count(level_count), .job_valid, .job_ready, .job_interp, .job_class, .job_sel,
    .job_d, .job_n, .cw_en, .cw_addr, .cw_data);

  crl_back #(.MAX_LEVELS(MAX_LEVELS), .CW(CW)) u_back (
    .clk, .rst, .job_valid, .job_ready, .job_interp, .job_class, .job_sel,
    .job_d, .job_n, .cw_en, .cw_addr, .cw_data, .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .out_data(out_ch.data));

endmodule
